@@ rtl/spisq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// SCSI initiator phase sequencer package
// Word types, action and opcode codes and sizing constants shared by the
// sequencer modules.
// ----------------------------------------------------------------------------
package spisq_pkg;

   localparam int FIFO_CHUNK  = 16;
   localparam int MAX_TRIES   = 8;
   localparam int MAX_RESULTS = 4;

   localparam int CHUNK_W = $clog2(FIFO_CHUNK + 1);
   localparam int TRIES_W = $clog2(MAX_TRIES + 1);
   localparam int COUNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [13:0] TIMEOUT_RESET = 14'd15000;
   localparam logic [13:0] ELAPSED_MAX   = 14'h3FFF;
   localparam logic [16:0] MAX_TRANSFER  = 17'h10000;
   localparam logic [4:0]  MAX_CDB       = 5'd20;
   localparam logic [2:0]  PHASE_DATA_IN = 3'b011;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_EVENT = 2'd1;
   localparam logic [1:0] CMD_TICK  = 2'd2;

   localparam logic [2:0] ACT_ISSUE      = 3'd0;
   localparam logic [2:0] ACT_WRITE_FIFO = 3'd1;
   localparam logic [2:0] ACT_READ_FIFO  = 3'd2;
   localparam logic [2:0] ACT_RESET      = 3'd3;
   localparam logic [2:0] ACT_CLEAR      = 3'd4;
   localparam logic [2:0] ACT_FINISH     = 3'd5;

   localparam logic [3:0] OP_NONE      = 4'd0;
   localparam logic [3:0] OP_ARBITRATE = 4'd1;
   localparam logic [3:0] OP_SELECT    = 4'd2;
   localparam logic [3:0] OP_COMMAND   = 4'd3;
   localparam logic [3:0] OP_STATUS    = 4'd4;
   localparam logic [3:0] OP_DATA_OUT  = 4'd5;
   localparam logic [3:0] OP_DATA_IN   = 4'd6;
   localparam logic [3:0] OP_MSG_IN    = 4'd8;
   localparam logic [3:0] OP_BUS_FREE  = 4'd9;

   localparam logic [1:0] RES_SUCCESS = 2'd0;
   localparam logic [1:0] RES_FAILED  = 2'd1;
   localparam logic [1:0] RES_FATAL   = 2'd2;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [2:0]  target_id;
      logic [4:0]  cdb_length;
      logic [16:0] transfer_length;
      logic        write_dir;
      logic        has_buffer;
      logic        status_wanted;
      logic        bus_busy;
      logic [2:0]  int_bits;
      logic [5:0]  exc_bits;
      logic [2:0]  bus_phase;
      logic [3:0]  done_opcode;
   } spisq_req_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  opcode;
      logic [15:0] byte_count;
      logic [2:0]  dest_id;
      logic [1:0]  result_code;
      logic        last;
   } spisq_rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]                    count;
      spisq_rsp_type [MAX_RESULTS-1:0]       entry;
   } spisq_batch_type;

endpackage
`default_nettype wire

@@ rtl/spisq_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer core
// Holds the phase state and request context and turns one input word into
// the batch of result words that it causes.
// ----------------------------------------------------------------------------
module spisq_core (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire spisq_pkg::spisq_req_type item,
   input  wire logic [13:0]              timeout_ticks,
   output spisq_pkg::spisq_batch_type    batch
);
   import spisq_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ARB,
      ST_SEL,
      ST_LOOP,
      ST_SELTO,
      ST_PMBF
   } state_type;

   state_type           state_ff, state_in;
   logic [16:0]         remaining_ff, remaining_in;
   logic [CHUNK_W-1:0]  chunk_ff, chunk_in;
   logic [4:0]          cdb_ff, cdb_in;
   logic [2:0]          target_ff, target_in;
   logic                write_ff, write_in;
   logic                buffer_ff, buffer_in;
   logic [TRIES_W-1:0]  tries_ff, tries_in;
   logic [13:0]         elapsed_ff, elapsed_in;
   logic [16:0]         total_ff, total_in;

   function automatic spisq_rsp_type mk(input logic [2:0] action, input logic [3:0] op,
                                        input logic [15:0] cnt, input logic [2:0] dest,
                                        input logic [1:0] code);
      spisq_rsp_type r;
      r.action      = action;
      r.opcode      = op;
      r.byte_count  = cnt;
      r.dest_id     = dest;
      r.result_code = code;
      r.last        = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic [COUNT_W-1:0] n;
      logic [1:0]         tail;
      logic               do_datain;
      logic               do_chunk;
      logic               do_fail;
      logic               do_start;
      logic [CHUNK_W-1:0] c;

      state_in     = state_ff;
      remaining_in = remaining_ff;
      chunk_in     = chunk_ff;
      cdb_in       = cdb_ff;
      target_in    = target_ff;
      write_in     = write_ff;
      buffer_in    = buffer_ff;
      tries_in     = tries_ff;
      elapsed_in   = elapsed_ff;
      total_in     = total_ff;
      batch        = '0;
      n            = '0;
      do_datain    = 1'b0;
      do_chunk     = 1'b0;
      do_fail      = 1'b0;
      do_start     = 1'b0;
      c            = '0;
      tail         = '0;

      case (item.cmd)
         CMD_START: begin
            if (state_ff == ST_IDLE) begin
               if (!item.status_wanted || item.transfer_length > MAX_TRANSFER ||
                   item.cdb_length > MAX_CDB) begin
                  batch.entry[n[1:0]] = mk(ACT_FINISH, OP_NONE, 16'd0, 3'd0, RES_FATAL);
                  n = n + 1'b1;
               end else begin
                  target_in = item.target_id;
                  cdb_in    = item.cdb_length;
                  write_in  = item.write_dir;
                  buffer_in = item.has_buffer;
                  total_in  = item.transfer_length;
                  tries_in  = TRIES_W'(1);
                  do_start  = 1'b1;
               end
            end
         end
         CMD_EVENT: begin
            if (state_ff != ST_IDLE && item.int_bits != 3'd0) begin
               case (state_ff)
                  ST_ARB: begin
                     if (item.int_bits == 3'd1) begin
                        batch.entry[n[1:0]] = mk(ACT_CLEAR, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                        n = n + 1'b1;
                        batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_SELECT, 16'd0, 3'd0, RES_SUCCESS);
                        n = n + 1'b1;
                        state_in = ST_SEL;
                     end else begin
                        batch.entry[n[1:0]] = mk(ACT_RESET, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                        n = n + 1'b1;
                        batch.entry[n[1:0]] = mk(ACT_FINISH, OP_NONE, 16'd0, 3'd0, RES_FATAL);
                        n = n + 1'b1;
                        state_in = ST_IDLE;
                     end
                  end
                  ST_SEL: begin
                     if (item.int_bits != 3'd1 && item.exc_bits[0]) begin
                        batch.entry[n[1:0]] = mk(ACT_CLEAR, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                        n = n + 1'b1;
                        batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_BUS_FREE, 16'd0, 3'd0,
                                                 RES_SUCCESS);
                        n = n + 1'b1;
                        state_in = ST_SELTO;
                     end else begin
                        if (item.int_bits == 3'd1) begin
                           batch.entry[n[1:0]] = mk(ACT_CLEAR, OP_NONE, 16'd0, 3'd0,
                                                    RES_SUCCESS);
                           n = n + 1'b1;
                        end
                        batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_COMMAND, 16'(cdb_ff), 3'd0,
                                                 RES_SUCCESS);
                        n = n + 1'b1;
                        batch.entry[n[1:0]] = mk(ACT_WRITE_FIFO, OP_NONE, 16'(cdb_ff), 3'd0,
                                                 RES_SUCCESS);
                        n = n + 1'b1;
                        state_in = ST_LOOP;
                     end
                  end
                  ST_LOOP: begin
                     if (item.int_bits == 3'd1) begin
                        batch.entry[n[1:0]] = mk(ACT_CLEAR, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                        n = n + 1'b1;
                        case (item.done_opcode)
                           OP_COMMAND: begin
                              if (buffer_ff && remaining_ff != 17'd0) begin
                                 if (write_ff) begin
                                    batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_DATA_OUT,
                                                             remaining_ff[15:0], 3'd0,
                                                             RES_SUCCESS);
                                    n = n + 1'b1;
                                    batch.entry[n[1:0]] = mk(ACT_WRITE_FIFO, OP_NONE,
                                                             remaining_ff[15:0], 3'd0,
                                                             RES_SUCCESS);
                                    n = n + 1'b1;
                                 end else begin
                                    do_chunk = 1'b1;
                                 end
                              end else begin
                                 batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_STATUS, 16'd1, 3'd0,
                                                          RES_SUCCESS);
                                 n = n + 1'b1;
                              end
                           end
                           OP_STATUS: begin
                              batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_MSG_IN, 16'd1, 3'd0,
                                                       RES_SUCCESS);
                              n = n + 1'b1;
                           end
                           OP_DATA_OUT: begin
                              batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_STATUS, 16'd1, 3'd0,
                                                       RES_SUCCESS);
                              n = n + 1'b1;
                           end
                           OP_DATA_IN: begin
                              do_datain = 1'b1;
                           end
                           OP_MSG_IN: begin
                              batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_BUS_FREE, 16'd0, 3'd0,
                                                       RES_SUCCESS);
                              n = n + 1'b1;
                           end
                           OP_BUS_FREE: begin
                              batch.entry[n[1:0]] = mk(ACT_READ_FIFO, OP_NONE, 16'd1, 3'd0,
                                                       RES_SUCCESS);
                              n = n + 1'b1;
                              batch.entry[n[1:0]] = mk(ACT_READ_FIFO, OP_NONE, 16'd1, 3'd0,
                                                       RES_SUCCESS);
                              n = n + 1'b1;
                              batch.entry[n[1:0]] = mk(ACT_FINISH, OP_NONE, 16'd0, 3'd0,
                                                       RES_SUCCESS);
                              n = n + 1'b1;
                              state_in = ST_IDLE;
                           end
                           default: begin
                           end
                        endcase
                     end else if (item.int_bits[1] && item.exc_bits[1]) begin
                        batch.entry[n[1:0]] = mk(ACT_CLEAR, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                        n = n + 1'b1;
                        batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_BUS_FREE, 16'd0, 3'd0,
                                                 RES_SUCCESS);
                        n = n + 1'b1;
                        state_in = ST_PMBF;
                     end else begin
                        do_fail = 1'b1;
                     end
                  end
                  ST_SELTO: begin
                     batch.entry[n[1:0]] = mk(ACT_CLEAR, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                     n = n + 1'b1;
                     batch.entry[n[1:0]] = mk(ACT_FINISH, OP_NONE, 16'd0, 3'd0, RES_FATAL);
                     n = n + 1'b1;
                     state_in = ST_IDLE;
                  end
                  ST_PMBF: begin
                     batch.entry[n[1:0]] = mk(ACT_CLEAR, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                     n = n + 1'b1;
                     if (item.bus_phase == PHASE_DATA_IN) begin
                        state_in  = ST_LOOP;
                        do_datain = 1'b1;
                     end else begin
                        do_fail = 1'b1;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         CMD_TICK: begin
            if (state_ff != ST_IDLE) begin
               if (elapsed_ff < ELAPSED_MAX) begin
                  elapsed_in = elapsed_ff + 14'd1;
               end
               if (elapsed_in >= timeout_ticks) begin
                  if (state_ff == ST_ARB || state_ff == ST_SELTO) begin
                     batch.entry[n[1:0]] = mk((state_ff == ST_ARB) ? ACT_RESET : ACT_CLEAR,
                                              OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
                     n = n + 1'b1;
                     batch.entry[n[1:0]] = mk(ACT_FINISH, OP_NONE, 16'd0, 3'd0, RES_FATAL);
                     n = n + 1'b1;
                     state_in = ST_IDLE;
                  end else begin
                     do_fail = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (do_datain) begin
         if (chunk_ff != '0) begin
            batch.entry[n[1:0]] = mk(ACT_READ_FIFO, OP_NONE, 16'(chunk_ff), 3'd0, RES_SUCCESS);
            n = n + 1'b1;
         end
         remaining_in = (remaining_ff > 17'(chunk_ff)) ? remaining_ff - 17'(chunk_ff) : 17'd0;
         if (remaining_in == 17'd0) begin
            batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_STATUS, 16'd1, 3'd0, RES_SUCCESS);
            n = n + 1'b1;
         end else begin
            do_chunk = 1'b1;
         end
      end

      if (do_chunk) begin
         c = (remaining_in < 17'(FIFO_CHUNK)) ? remaining_in[CHUNK_W-1:0]
                                              : CHUNK_W'(FIFO_CHUNK);
         chunk_in = c;
         batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_DATA_IN, 16'(c), 3'd0, RES_SUCCESS);
         n = n + 1'b1;
      end

      if (do_fail) begin
         if (tries_ff >= TRIES_W'(MAX_TRIES)) begin
            batch.entry[n[1:0]] = mk(ACT_FINISH, OP_NONE, 16'd0, 3'd0, RES_FAILED);
            n = n + 1'b1;
            state_in = ST_IDLE;
         end else begin
            tries_in = tries_ff + 1'b1;
            do_start = 1'b1;
         end
      end

      if (do_start) begin
         if (item.bus_busy) begin
            batch.entry[n[1:0]] = mk(ACT_RESET, OP_NONE, 16'd0, 3'd0, RES_SUCCESS);
            n = n + 1'b1;
         end
         elapsed_in   = 14'd0;
         chunk_in     = '0;
         remaining_in = total_in;
         batch.entry[n[1:0]] = mk(ACT_ISSUE, OP_ARBITRATE, 16'd0, target_in, RES_SUCCESS);
         n = n + 1'b1;
         state_in = ST_ARB;
      end

      if (n != '0) begin
         tail = n[1:0] - 2'd1;
         batch.entry[tail].last = 1'b1;
      end
      batch.count = n;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= '0;
         chunk_ff     <= '0;
         cdb_ff       <= '0;
         target_ff    <= '0;
         write_ff     <= 1'b0;
         buffer_ff    <= 1'b0;
         tries_ff     <= '0;
         elapsed_ff   <= '0;
         total_ff     <= '0;
      end else if (step) begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         chunk_ff     <= chunk_in;
         cdb_ff       <= cdb_in;
         target_ff    <= target_in;
         write_ff     <= write_in;
         buffer_ff    <= buffer_in;
         tries_ff     <= tries_in;
         elapsed_ff   <= elapsed_in;
         total_ff     <= total_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/spisq_rsp_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Result queue
// Holds the batch of result words of one input word and presents them on
// the result channel one word per clock while the receiver does not stall, oldest first.
// ----------------------------------------------------------------------------
module spisq_rsp_queue (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       load,
   input  wire spisq_pkg::spisq_batch_type batch,
   output logic                            can_load,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output spisq_pkg::spisq_rsp_type        rsp_data
);
   import spisq_pkg::*;

   spisq_rsp_type [MAX_RESULTS-1:0] entry_ff, entry_in;
   logic [COUNT_W-1:0]              count_ff, count_in;
   logic                            drain;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = entry_ff[0];
   assign drain     = rsp_valid && !rsp_stall;
   assign can_load  = (count_ff == '0) || (count_ff == COUNT_W'(1) && drain);

   always_comb begin
      entry_in = entry_ff;
      count_in = count_ff;
      if (load) begin
         entry_in = batch.entry;
         count_in = batch.count;
      end else if (drain) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            entry_in[i] = entry_ff[i + 1];
         end
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

@@ rtl/scsi_initiator_phase_sequencer.sv @@
`default_nettype none
// A request word accepted into the input register goes to the sequencer core once the result
// queue can take its batch; its result words then leave from the registered result queue.
// Throughput: one request word per clock while each causes at most one result word and the
// receiver does not stall; a word with more holds the next one back while its batch drains.
// Reset clears the sequencer to idle, empties the result queue and loads the timeout
// register with 15000 ticks.
// ----------------------------------------------------------------------------
// SCSI initiator phase sequencer
// Input register, sequencer core, result queue and the timeout register.
// ----------------------------------------------------------------------------
module scsi_initiator_phase_sequencer (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire spisq_pkg::spisq_req_type req_data,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output spisq_pkg::spisq_rsp_type      rsp_data,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [13:0]              csr_data
);
   import spisq_pkg::*;

   spisq_req_type   item_ff;
   logic            item_valid_ff;
   logic [13:0]     timeout_ff;
   logic            can_load;
   logic            step;
   spisq_batch_type batch;

   assign csr_ready = 1'b1;
   assign step      = item_valid_ff && can_load;
   assign req_stall = item_valid_ff && !can_load;

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
      if (reset) begin
         item_valid_ff <= 1'b0;
         timeout_ff    <= TIMEOUT_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            item_valid_ff <= 1'b1;
         end else if (step) begin
            item_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            timeout_ff <= csr_data;
         end
      end
   end

   spisq_core u_core (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (item_ff),
      .timeout_ticks (timeout_ff),
      .batch         (batch)
   );

   spisq_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .load      (step),
      .batch     (batch),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

@@ rtl/spisq_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Sequencer port checker
// Checks result words seen on the top level ports.
// ----------------------------------------------------------------------------
module spisq_checker (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_stall,
   input wire spisq_pkg::spisq_rsp_type rsp_data
);
   import spisq_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("Stalled result word changed.");

   a_finish_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action == ACT_FINISH |-> rsp_data.last)
      else $error("Finish word is not the last word of its batch.");

   a_code_on_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_FINISH |-> rsp_data.result_code == RES_SUCCESS)
      else $error("Result code set on a word that is not a finish.");

   a_opcode_on_issue: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action != ACT_ISSUE |-> rsp_data.opcode == OP_NONE &&
      rsp_data.dest_id == 3'd0)
      else $error("Opcode or destination set on a word that issues no command.");

endmodule

bind scsi_initiator_phase_sequencer spisq_checker u_checker (.*);
`default_nettype wire

@@ verif/scsi_initiator_phase_sequencer_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SCSI initiator phase sequencer testbench
// Drives start, controller event and tick words through bursty traffic with
// receiver stalls. Every accepted request word runs through a phase model
// kept in the bench, and each result word is checked field by field against
// the queue of predicted controller actions.
// ----------------------------------------------------------------------------
module scsi_initiator_phase_sequencer_test;
   import spisq_pkg::*;

   localparam int QUIET_LIMIT     = 2000;
   localparam int HOLD_OFF_CYCLES = 200;

   localparam logic [1:0] CMD_UNUSED         = 2'd3;
   localparam logic [2:0] INT_DONE           = 3'b001;
   localparam logic [2:0] INT_EXC_FLAG       = 3'b010;
   localparam logic [2:0] INT_ERR_FLAG       = 3'b100;
   localparam logic [5:0] EXC_SEL_TIMEOUT    = 6'b000001;
   localparam logic [5:0] EXC_PHASE_MISMATCH = 6'b000010;
   localparam logic [2:0] PHASE_OTHER        = 3'b110;

   localparam int STALL_NONE     = 0;
   localparam int STALL_LIGHT    = 1;
   localparam int STALL_HEAVY    = 2;
   localparam int STALL_PERIODIC = 3;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_ARBITRATE,
      SEQ_SELECT,
      SEQ_PHASES,
      SEQ_SEL_TIMEOUT,
      SEQ_MISMATCH_FREE
   } seq_state_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_stall;
   spisq_req_type req_data;
   logic          rsp_valid;
   logic          rsp_stall;
   spisq_rsp_type rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [13:0]   csr_data;

   seq_state_type seq_state;
   logic [16:0]   bytes_left;
   logic [16:0]   request_bytes;
   logic [4:0]    chunk_size;
   logic [4:0]    cdb_bytes;
   logic [2:0]    target;
   logic          write_out;
   logic          buffered;
   logic [3:0]    attempts;
   logic [13:0]   ticks_elapsed;
   logic [13:0]   timeout_limit;
   logic [3:0]    awaited_opcode;

   spisq_rsp_type step_actions[$];
   spisq_rsp_type expected_actions[$];

   int failures;
   int stall_mode;
   int fault_pct;
   int tick_pct;
   int burst_left;
   bit sender_bursty;
   bit hold_off_request;

   scsi_initiator_phase_sequencer i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void add_action(logic [2:0] act, logic [3:0] op, logic [16:0] count,
                                      logic [2:0] dest, logic [1:0] code);
      spisq_rsp_type r;
      r.action      = act;
      r.opcode      = op;
      r.byte_count  = count[15:0];
      r.dest_id     = dest;
      r.result_code = code;
      r.last        = 1'b0;
      step_actions.push_back(r);
      if (act == ACT_ISSUE) awaited_opcode = op;
   endfunction

   function automatic void finish_command(logic [1:0] code);
      add_action(ACT_FINISH, OP_NONE, 0, 0, code);
      seq_state = SEQ_IDLE;
   endfunction

   function automatic void begin_attempt(logic busy);
      if (busy) add_action(ACT_RESET, OP_NONE, 0, 0, RES_SUCCESS);
      ticks_elapsed = '0;
      chunk_size    = '0;
      bytes_left    = request_bytes;
      add_action(ACT_ISSUE, OP_ARBITRATE, 0, target, RES_SUCCESS);
      seq_state = SEQ_ARBITRATE;
   endfunction

   function automatic void retry_or_give_up(logic busy);
      if (attempts >= MAX_TRIES) begin
         finish_command(RES_FAILED);
      end else begin
         attempts = attempts + 1;
         begin_attempt(busy);
      end
   endfunction

   function automatic void load_chunk();
      chunk_size = (bytes_left < FIFO_CHUNK) ? bytes_left[4:0] : 5'(FIFO_CHUNK);
      add_action(ACT_ISSUE, OP_DATA_IN, chunk_size, 0, RES_SUCCESS);
   endfunction

   function automatic void data_in_step();
      if (chunk_size != 0) add_action(ACT_READ_FIFO, OP_NONE, chunk_size, 0, RES_SUCCESS);
      bytes_left = (bytes_left > chunk_size) ? bytes_left - chunk_size : '0;
      if (bytes_left == 0) add_action(ACT_ISSUE, OP_STATUS, 1, 0, RES_SUCCESS);
      else load_chunk();
   endfunction

   function automatic void command_phase();
      add_action(ACT_ISSUE, OP_COMMAND, cdb_bytes, 0, RES_SUCCESS);
      add_action(ACT_WRITE_FIFO, OP_NONE, cdb_bytes, 0, RES_SUCCESS);
      seq_state = SEQ_PHASES;
   endfunction

   task automatic compute_actions(input spisq_req_type w);
      spisq_rsp_type r;
      step_actions.delete();
      case (w.cmd)
         CMD_START: begin
            if (seq_state == SEQ_IDLE) begin
               if (!w.status_wanted || w.transfer_length > MAX_TRANSFER
                   || w.cdb_length > MAX_CDB) begin
                  finish_command(RES_FATAL);
               end else begin
                  target        = w.target_id;
                  cdb_bytes     = w.cdb_length;
                  write_out     = w.write_dir;
                  buffered      = w.has_buffer;
                  request_bytes = w.transfer_length;
                  attempts      = 1;
                  begin_attempt(w.bus_busy);
               end
            end
         end
         CMD_EVENT: begin
            if (seq_state != SEQ_IDLE && w.int_bits != 0) begin
               case (seq_state)
                  SEQ_ARBITRATE: begin
                     if (w.int_bits == INT_DONE) begin
                        add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                        add_action(ACT_ISSUE, OP_SELECT, 0, 0, RES_SUCCESS);
                        seq_state = SEQ_SELECT;
                     end else begin
                        add_action(ACT_RESET, OP_NONE, 0, 0, RES_SUCCESS);
                        finish_command(RES_FATAL);
                     end
                  end
                  SEQ_SELECT: begin
                     if (w.int_bits == INT_DONE) begin
                        add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                        command_phase();
                     end else if ((w.exc_bits & EXC_SEL_TIMEOUT) != 0) begin
                        add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                        add_action(ACT_ISSUE, OP_BUS_FREE, 0, 0, RES_SUCCESS);
                        seq_state = SEQ_SEL_TIMEOUT;
                     end else begin
                        command_phase();
                     end
                  end
                  SEQ_PHASES: begin
                     if (w.int_bits == INT_DONE) begin
                        add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                        case (w.done_opcode)
                           OP_COMMAND: begin
                              if (buffered && bytes_left != 0) begin
                                 if (write_out) begin
                                    add_action(ACT_ISSUE, OP_DATA_OUT, bytes_left, 0, RES_SUCCESS);
                                    add_action(ACT_WRITE_FIFO, OP_NONE, bytes_left, 0,
                                               RES_SUCCESS);
                                 end else begin
                                    load_chunk();
                                 end
                              end else begin
                                 add_action(ACT_ISSUE, OP_STATUS, 1, 0, RES_SUCCESS);
                              end
                           end
                           OP_STATUS:   add_action(ACT_ISSUE, OP_MSG_IN, 1, 0, RES_SUCCESS);
                           OP_DATA_OUT: add_action(ACT_ISSUE, OP_STATUS, 1, 0, RES_SUCCESS);
                           OP_DATA_IN:  data_in_step();
                           OP_MSG_IN:   add_action(ACT_ISSUE, OP_BUS_FREE, 0, 0, RES_SUCCESS);
                           OP_BUS_FREE: begin
                              add_action(ACT_READ_FIFO, OP_NONE, 1, 0, RES_SUCCESS);
                              add_action(ACT_READ_FIFO, OP_NONE, 1, 0, RES_SUCCESS);
                              finish_command(RES_SUCCESS);
                           end
                           default: ;
                        endcase
                     end else if ((w.int_bits & INT_EXC_FLAG) != 0
                                  && (w.exc_bits & EXC_PHASE_MISMATCH) != 0) begin
                        add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                        add_action(ACT_ISSUE, OP_BUS_FREE, 0, 0, RES_SUCCESS);
                        seq_state = SEQ_MISMATCH_FREE;
                     end else begin
                        retry_or_give_up(w.bus_busy);
                     end
                  end
                  SEQ_SEL_TIMEOUT: begin
                     add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                     finish_command(RES_FATAL);
                  end
                  SEQ_MISMATCH_FREE: begin
                     add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                     if (w.bus_phase == PHASE_DATA_IN) begin
                        seq_state = SEQ_PHASES;
                        data_in_step();
                     end else begin
                        retry_or_give_up(w.bus_busy);
                     end
                  end
                  default: seq_state = SEQ_IDLE;
               endcase
            end
         end
         CMD_TICK: begin
            if (seq_state != SEQ_IDLE) begin
               if (ticks_elapsed < ELAPSED_MAX) ticks_elapsed = ticks_elapsed + 1;
               if (ticks_elapsed >= timeout_limit) begin
                  if (seq_state == SEQ_ARBITRATE) begin
                     add_action(ACT_RESET, OP_NONE, 0, 0, RES_SUCCESS);
                     finish_command(RES_FATAL);
                  end else if (seq_state == SEQ_SEL_TIMEOUT) begin
                     add_action(ACT_CLEAR, OP_NONE, 0, 0, RES_SUCCESS);
                     finish_command(RES_FATAL);
                  end else begin
                     retry_or_give_up(w.bus_busy);
                  end
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < step_actions.size(); i++) begin
         r = step_actions[i];
         r.last = (i == step_actions.size() - 1);
         expected_actions.push_back(r);
      end
   endtask

   function automatic spisq_req_type random_fields();
      logic [63:0] bits;
      bits = {$urandom(), $urandom()};
      return spisq_req_type'(bits[$bits(spisq_req_type)-1:0]);
   endfunction

   function automatic spisq_req_type start_word(logic [2:0] tgt, logic [4:0] cdb,
                                                 logic [16:0] len, logic wr,
                                                 logic with_buffer, logic busy);
      spisq_req_type w;
      w                 = random_fields();
      w.cmd             = CMD_START;
      w.target_id       = tgt;
      w.cdb_length      = cdb;
      w.transfer_length = len;
      w.write_dir       = wr;
      w.has_buffer      = with_buffer;
      w.status_wanted   = 1'b1;
      w.bus_busy        = busy;
      return w;
   endfunction

   function automatic spisq_req_type event_word(logic [2:0] ints, logic [5:0] exc,
                                                 logic [2:0] phase, logic [3:0] done);
      spisq_req_type w;
      w             = random_fields();
      w.cmd         = CMD_EVENT;
      w.int_bits    = ints;
      w.exc_bits    = exc;
      w.bus_phase   = phase;
      w.done_opcode = done;
      return w;
   endfunction

   function automatic spisq_req_type tick_word();
      spisq_req_type w;
      w     = random_fields();
      w.cmd = CMD_TICK;
      return w;
   endfunction

   // Mostly words that move the current command forward, with faults and noise mixed in.
   function automatic spisq_req_type random_request();
      spisq_req_type w;
      int roll;
      bit fault;
      w    = random_fields();
      roll = $urandom_range(0, 99);
      if (seq_state == SEQ_IDLE) begin
         if (roll < 6) return w;
         w.cmd = CMD_START;
         if (roll >= 9) begin
            w.status_wanted = 1'b1;
            w.cdb_length    = $urandom_range(0, 20);
            if (w.has_buffer && !w.write_dir) w.transfer_length = $urandom_range(0, 72);
            else if (roll < 18) w.transfer_length = MAX_TRANSFER;
            else if (roll < 70) w.transfer_length = $urandom_range(0, 300);
            else w.transfer_length = $urandom_range(0, 65536);
         end
         return w;
      end
      if (roll < tick_pct) begin
         w.cmd = CMD_TICK;
         return w;
      end
      if (roll < tick_pct + 4) begin
         case ($urandom_range(0, 2))
            0: w.cmd = CMD_START;
            1: w.cmd = CMD_UNUSED;
            default: begin
               w.cmd      = CMD_EVENT;
               w.int_bits = '0;
            end
         endcase
         return w;
      end
      w.cmd = CMD_EVENT;
      fault = $urandom_range(0, 99) < fault_pct;
      case (seq_state)
         SEQ_ARBITRATE: begin
            if (fault && $urandom_range(0, 3) == 0) w.int_bits = $urandom_range(2, 7);
            else w.int_bits = INT_DONE;
         end
         SEQ_SELECT: begin
            if (fault) w.int_bits = $urandom_range(2, 7);
            else w.int_bits = INT_DONE;
         end
         SEQ_PHASES: begin
            if (fault) begin
               w.int_bits = $urandom_range(2, 7);
            end else begin
               w.int_bits = INT_DONE;
               if ($urandom_range(0, 9) != 0) w.done_opcode = awaited_opcode;
            end
         end
         SEQ_MISMATCH_FREE: begin
            w.int_bits = $urandom_range(1, 7);
            if ($urandom_range(0, 5) != 0) w.bus_phase = PHASE_DATA_IN;
         end
         default: w.int_bits = $urandom_range(1, 7);
      endcase
      return w;
   endfunction

   task automatic send_request(input spisq_req_type w);
      int gap;
      gap = 0;
      if (sender_bursty && burst_left == 0) begin
         gap        = $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
      end
      if (burst_left > 0) burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (req_stall);
      compute_actions(w);
   endtask

   task automatic wait_until_quiet();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_actions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_timeout_ticks(input logic [13:0] ticks);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= ticks;
      do @(posedge clock); while (!csr_ready);
      timeout_limit = ticks;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic start_check_test();
      spisq_req_type w;
      w = start_word(3'd5, 5'd4, 17'd8, 1'b1, 1'b1, 1'b0);
      w.status_wanted = 1'b0;
      send_request(w);
      send_request(start_word(3'd2, 5'd21, 17'd8, 1'b0, 1'b1, 1'b0));
      send_request(start_word(3'd3, 5'd6, 17'd65537, 1'b1, 1'b1, 1'b1));
      send_request(tick_word());
      send_request(event_word(INT_DONE | INT_EXC_FLAG | INT_ERR_FLAG, '1, PHASE_DATA_IN,
                              OP_STATUS));
      w     = random_fields();
      w.cmd = CMD_UNUSED;
      send_request(w);
   endtask

   task automatic write_command_test();
      send_request(start_word(3'd7, 5'd20, MAX_TRANSFER, 1'b1, 1'b1, 1'b1));
      send_request(start_word(3'd1, 5'd2, 17'd4, 1'b0, 1'b0, 1'b0));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_ARBITRATE));
      send_request(event_word('0, '1, PHASE_OTHER, OP_SELECT));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_SELECT));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_COMMAND));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, 4'd7));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_DATA_OUT));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_STATUS));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_MSG_IN));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_BUS_FREE));
   endtask

   task automatic data_in_test();
      send_request(start_word(3'd0, 5'd0, 17'd20, 1'b0, 1'b1, 1'b0));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_NONE));
      send_request(event_word(INT_ERR_FLAG, '0, PHASE_OTHER, OP_NONE));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_COMMAND));
      send_request(event_word(INT_EXC_FLAG, EXC_PHASE_MISMATCH, PHASE_OTHER, OP_NONE));
      send_request(event_word(INT_DONE, '0, PHASE_DATA_IN, OP_NONE));
      send_request(event_word(INT_EXC_FLAG | INT_ERR_FLAG, EXC_SEL_TIMEOUT, PHASE_OTHER,
                              OP_NONE));
      send_request(event_word(INT_EXC_FLAG, '0, PHASE_OTHER, OP_NONE));
   endtask

   task automatic exception_test();
      wait_until_quiet();
      write_timeout_ticks(14'd1);
      send_request(start_word(3'd4, 5'd10, 17'd0, 1'b0, 1'b0, 1'b1));
      send_request(tick_word());
      send_request(start_word(3'd6, 5'd12, 17'd100, 1'b1, 1'b1, 1'b0));
      send_request(event_word(INT_DONE, '0, PHASE_OTHER, OP_NONE));
      send_request(event_word(INT_EXC_FLAG, EXC_SEL_TIMEOUT, PHASE_OTHER, OP_NONE));
      send_request(tick_word());
   endtask

   task automatic random_traffic_test();
      logic [13:0] timeout_choices [6] = '{14'd25, 14'd1, 14'd7, 14'd300, 14'd2, 14'd16383};
      int fault_choices [6] = '{10, 10, 20, 60, 10, 15};
      int stall_choices [6] = '{STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY,
                                STALL_NONE, STALL_LIGHT};
      for (int p = 0; p < 6; p++) begin
         wait_until_quiet();
         write_timeout_ticks(timeout_choices[p]);
         fault_pct     = fault_choices[p];
         tick_pct      = 4 + 3 * p;
         stall_mode    = stall_choices[p];
         sender_bursty = (p % 3) != 2;
         repeat (52) send_request(random_request());
      end
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic pressure_test();
      sender_bursty    = 1'b0;
      stall_mode       = STALL_LIGHT;
      hold_off_request = 1'b1;
      repeat (40) send_request(random_request());
   endtask

   initial begin : receiver
      int stall_phase;
      rsp_stall   = 1'b0;
      stall_phase = 0;
      forever begin
         @(negedge clock);
         stall_phase = (stall_phase + 1) % 7;
         if (hold_off_request) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
            hold_off_request = 1'b0;
         end else begin
            case (stall_mode)
               STALL_LIGHT:    rsp_stall <= $urandom_range(0, 99) < 30;
               STALL_HEAVY:    rsp_stall <= $urandom_range(0, 99) < 70;
               STALL_PERIODIC: rsp_stall <= stall_phase >= 4;
               default:        rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endfunction

   always @(posedge clock) begin : check_results
      spisq_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            $error("result word with none expected: action %0d", rsp_data.action);
            failures++;
         end else begin
            want = expected_actions.pop_front();
            compare_field("action", want.action, rsp_data.action);
            compare_field("opcode", want.opcode, rsp_data.opcode);
            compare_field("byte_count", want.byte_count, rsp_data.byte_count);
            compare_field("dest_id", want.dest_id, rsp_data.dest_id);
            compare_field("result_code", want.result_code, rsp_data.result_code);
            compare_field("last", want.last, rsp_data.last);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)
             || (csr_valid && csr_ready)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      seq_state        = SEQ_IDLE;
      bytes_left       = '0;
      request_bytes    = '0;
      chunk_size       = '0;
      cdb_bytes        = '0;
      target           = '0;
      write_out        = 1'b0;
      buffered         = 1'b0;
      attempts         = '0;
      ticks_elapsed    = '0;
      timeout_limit    = TIMEOUT_RESET;
      awaited_opcode   = OP_NONE;
      failures         = 0;
      stall_mode       = STALL_LIGHT;
      fault_pct        = 10;
      tick_pct         = 8;
      burst_left       = 0;
      sender_bursty    = 1'b1;
      hold_off_request = 1'b0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      start_check_test();
      write_command_test();
      data_in_test();
      exception_test();
      random_traffic_test();
      pressure_test();
      wait_until_quiet();
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
